// ===== design/fcv_pkg.sv =====
package fcv_pkg;

	// default filter capacity
	localparam int MAX_TAPS_DEF = 16;

	// field widths
	localparam int DATA_W = 16;
	localparam int IDX_W  = 4;
	localparam int CFG_W  = 5;
	localparam int PROD_W = 2 * DATA_W;
	localparam int SUM_W  = 36;

	localparam logic [CFG_W-1:0] TAP_COUNT_RST = CFG_W'(10);

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_FILTER = 1'b1
	} op_t;

	// control broadcast to every cell of the chain
	typedef struct packed {
		logic adv;
		logic shift;
		logic clear;
	} fcv_cell_ctl_t;

endpackage

// ===== design/fcv_in_if.sv =====
interface fcv_in_if import fcv_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     operation;
	logic [IDX_W-1:0]         tap_index;
	logic signed [DATA_W-1:0] value;
	logic                     last;

	modport source (output valid, output operation, output tap_index, output value,
		output last, input ready);
	modport sink (input valid, input operation, input tap_index, input value,
		input last, output ready);
endinterface

// ===== design/fcv_out_if.sv =====
interface fcv_out_if import fcv_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [SUM_W-1:0] sum_out;
	logic                    final_res;

	modport source (output valid, output sum_out, output final_res, input ready);
	modport sink (input valid, input sum_out, input final_res, output ready);
endinterface

// ===== design/fcv_cell.sv =====
module fcv_cell import fcv_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  fcv_cell_ctl_t            ctl,
	input  logic                     use_tap,
	input  logic                     coef_we,
	input  logic signed [DATA_W-1:0] coef_wdata,
	input  logic signed [DATA_W-1:0] tap_in,
	output logic signed [DATA_W-1:0] sample_q,
	output logic signed [PROD_W-1:0] prod_s1
);

	logic signed [DATA_W-1:0] coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q   <= '0;
			sample_q <= '0;
		end else begin
			if (coef_we) begin
				coef_q <= coef_wdata;
			end
			// clear wins over shift on the closing output of a sequence
			if (ctl.clear) begin
				sample_q <= '0;
			end else if (ctl.shift) begin
				sample_q <= tap_in;
			end
		end
	end

	// tap product, zero for taps beyond the filter length
	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			prod_s1 <= use_tap ? PROD_W'(tap_in * coef_q) : '0;
		end
	end

endmodule

// ===== design/fcv_sum_tree.sv =====
module fcv_sum_tree import fcv_pkg::*; #(
	parameter int N = MAX_TAPS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic                     in_vld,
	input  logic                     in_final,
	input  logic signed [PROD_W-1:0] prod [N],
	output logic                     out_vld,
	output logic                     out_final,
	output logic signed [SUM_W-1:0]  sum_out
);

	localparam int LEVELS = $clog2(N);
	localparam int P      = 1 << LEVELS;

	logic signed [SUM_W-1:0] leaf [P];
	logic signed [SUM_W-1:0] node_q [P-1];
	logic [LEVELS-1:0]       vld_q;
	logic [LEVELS-1:0]       fin_q;

	// leaves padded with zero up to a power of two
	always_comb begin
		for (int j = 0; j < P; j++) begin
			leaf[j] = (j < N) ? SUM_W'(prod[j]) : '0;
		end
	end

	// heap ordered tree, root at node 0, one register level per tree level
	for (genvar i = 0; i < P - 1; i++) begin : g_node
		localparam int L = 2 * i + 1;
		localparam int R = 2 * i + 2;
		if (L >= P - 1) begin : g_leaf_kids
			always_ff @(posedge clk) begin
				if (adv) begin
					node_q[i] <= leaf[L-(P-1)] + leaf[R-(P-1)];
				end
			end
		end else begin : g_node_kids
			always_ff @(posedge clk) begin
				if (adv) begin
					node_q[i] <= node_q[L] + node_q[R];
				end
			end
		end
	end

	for (genvar l = 0; l < LEVELS; l++) begin : g_vld
		if (l == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_q[l] <= 1'b0;
					fin_q[l] <= 1'b0;
				end else if (adv) begin
					vld_q[l] <= in_vld;
					fin_q[l] <= in_final;
				end
			end
		end else begin : g_rest
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_q[l] <= 1'b0;
					fin_q[l] <= 1'b0;
				end else if (adv) begin
					vld_q[l] <= vld_q[l-1];
					fin_q[l] <= fin_q[l-1];
				end
			end
		end
	end

	assign out_vld   = vld_q[LEVELS-1];
	assign out_final = fin_q[LEVELS-1];
	assign sum_out   = node_q[0];

endmodule

// ===== design/fir_full_convolution.sv =====
// a filter sample's product is registered in the cells and then summed through
// the register levels of the tree; tail outputs follow one per cycle unless stalled
// input: one load or one sample per cycle unless stalled; a sample marked last
// holds off the input while the issue counter sends the M-1 tail outputs
// reset: arst_n clears coefficients, delay line and pipeline valids at once,
// tap_count returns to 10; no clearing pass
module fir_full_convolution import fcv_pkg::*; #(
	parameter int MAX_TAPS = MAX_TAPS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	fcv_in_if.sink           item,
	fcv_out_if.source        result
);

	// filter length can reach MAX_TAPS, tail count reaches MAX_TAPS-1
	localparam int LEN_W = $clog2(MAX_TAPS + 1);
	localparam int CNT_W = $clog2(MAX_TAPS);

	logic [CFG_W-1:0]         tap_count_q;
	logic [LEN_W-1:0]         len;
	logic [CNT_W-1:0]         flush_cnt_q;
	logic                     flushing;
	logic                     adv;
	logic                     acc;
	logic                     load_fire;
	logic                     smp_fire;
	logic                     issue_vld;
	logic                     issue_final;
	logic signed [DATA_W-1:0] cur_sample;
	fcv_cell_ctl_t            cell_ctl;
	logic signed [DATA_W-1:0] dly [MAX_TAPS];
	logic signed [PROD_W-1:0] prod [MAX_TAPS];
	logic                     out_vld;
	logic                     dly_zero;

	// configuration register; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_COUNT_RST;
		end else if (cfg_we) begin
			tap_count_q <= cfg_wdata;
		end
	end

	// effective filter length: zero counts as one, saturate at capacity
	always_comb begin
		if (tap_count_q == '0) begin
			len = LEN_W'(1);
		end else if (int'(tap_count_q) > MAX_TAPS) begin
			len = LEN_W'(MAX_TAPS);
		end else begin
			len = LEN_W'(tap_count_q);
		end
	end

	// whole pipeline moves together; the tree root is the output register
	assign adv      = !out_vld || result.ready;
	assign flushing = (flush_cnt_q != '0);

	// input is held off while tail outputs are being issued
	assign item.ready = adv && !flushing;
	assign acc        = item.valid && item.ready;
	assign load_fire  = acc && (op_t'(item.operation) == OP_LOAD);
	assign smp_fire   = acc && (op_t'(item.operation) == OP_FILTER);

	// one output issued per cycle while the pipeline advances: either a new sample or a zero tail sample
	assign issue_vld  = smp_fire || (flushing && adv);
	assign cur_sample = smp_fire ? item.value : '0;

	always_comb begin
		if (smp_fire) begin
			issue_final = item.last && (len == LEN_W'(1));
		end else begin
			issue_final = (flush_cnt_q == CNT_W'(1));
		end
	end

	// tail counter, loaded with M-1 on a last sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_cnt_q <= '0;
		end else if (smp_fire && item.last && (len != LEN_W'(1))) begin
			flush_cnt_q <= CNT_W'(len - LEN_W'(1));
		end else if (flushing && adv) begin
			flush_cnt_q <= flush_cnt_q - CNT_W'(1);
		end
	end

	// delay line shifts on every issue and is wiped after the closing output
	assign cell_ctl.adv   = adv;
	assign cell_ctl.shift = issue_vld;
	assign cell_ctl.clear = issue_vld && issue_final;

	// chain of tap cells: cell k holds coefficient k and the sample for tap k+1
	for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
		logic signed [DATA_W-1:0] tap_in;
		if (k == 0) begin : g_head
			assign tap_in = cur_sample;
		end else begin : g_body
			assign tap_in = dly[k-1];
		end

		fcv_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (cell_ctl),
			.use_tap    (k < int'(len)),
			.coef_we    (load_fire && (int'(item.tap_index) == k)),
			.coef_wdata (item.value),
			.tap_in     (tap_in),
			.sample_q   (dly[k]),
			.prod_s1    (prod[k])
		);
	end

	// registered product valid and final flag ride alongside the tree
	logic prod_vld_s1;
	logic prod_fin_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s1 <= 1'b0;
			prod_fin_s1 <= 1'b0;
		end else if (adv) begin
			prod_vld_s1 <= issue_vld;
			prod_fin_s1 <= issue_vld && issue_final;
		end
	end

	fcv_sum_tree #(
		.N (MAX_TAPS)
	) u_sum_tree (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_vld    (prod_vld_s1),
		.in_final  (prod_fin_s1),
		.prod      (prod),
		.out_vld   (out_vld),
		.out_final (result.final_res),
		.sum_out   (result.sum_out)
	);

	assign result.valid = out_vld;

	always_comb begin
		dly_zero = 1'b1;
		for (int k = 0; k < MAX_TAPS; k++) begin
			if (dly[k] != '0) begin
				dly_zero = 1'b0;
			end
		end
	end

	// the closing output of a sequence leaves an empty delay line
	a_clear_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		issue_vld && issue_final |=> dly_zero)
		else $error("delay line not cleared after final output");

	// tail outputs are issued one at a time, counting down
	a_flush_count: assert property (@(posedge clk) disable iff (!arst_n)
		flushing && adv |=> flush_cnt_q == $past(flush_cnt_q) - CNT_W'(1))
		else $error("tail counter skipped");

	// a last sample with more than one tap starts a tail flush
	a_flush_start: assert property (@(posedge clk) disable iff (!arst_n)
		smp_fire && item.last && (len != LEN_W'(1)) |=> flushing && !item.ready)
		else $error("tail flush not started");

endmodule
